// ===== rtl/cda_pkg.sv =====
// ----------------------------------------------------------------------------
// cda_pkg
// Types, codes and the month length table shared by the calendar date block
// and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package cda_pkg;

   localparam int COUNT_BITS_DEFAULT = 16;

   localparam logic [3:0]  MONTHS_PER_YEAR = 4'd12;
   localparam logic [4:0]  LEAP_FEB_DAYS   = 5'd29;
   localparam logic [3:0]  FEBRUARY        = 4'd2;
   localparam logic [11:0] YEAR_MIN        = 12'd1900;
   localparam logic [11:0] YEAR_MID        = 12'd2000;
   localparam logic [11:0] YEAR_MAX        = 12'd2100;
   localparam logic [11:0] TOP_YEAR        = 12'd4095;
   localparam logic [5:0]  CENT_MIN        = 6'd19;
   localparam logic [5:0]  CENT_MID        = 6'd20;
   localparam logic [5:0]  CENT_MAX        = 6'd21;
   localparam logic [6:0]  LAST_REM        = 7'd99;

   typedef enum logic [1:0] {
      CMD_SET     = 2'd0,
      CMD_ADVANCE = 2'd1,
      CMD_COMPARE = 2'd2,
      CMD_NONE    = 2'd3
   } command_type;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_BAD_MONTH = 3'd1;
   localparam logic [2:0] ST_BAD_YEAR  = 3'd2;
   localparam logic [2:0] ST_BAD_DAY   = 3'd3;
   localparam logic [2:0] ST_OVERFLOW  = 3'd4;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic [1:0]  command;
      logic [4:0]  new_day;
      logic [3:0]  new_month;
      logic [11:0] new_year;
      logic [15:0] day_count;
   } req_type;

   typedef struct packed {
      logic [4:0]  cur_day;
      logic [3:0]  cur_month;
      logic [11:0] cur_year;
      logic [2:0]  status;
      logic        is_earlier;
   } rsp_type;

   // Length of a month; codes outside 1 to 12 give zero so no day fits.
   function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
      logic [4:0] len;
      case (month)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
         4'd2:                                      len = leap ? LEAP_FEB_DAYS : 5'd28;
         default:                                   len = 5'd0;
      endcase
      return len;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/calendar_date_advance_top.sv =====
// ----------------------------------------------------------------------------
// calendar_date_advance_top
// Holds a Gregorian date and runs set, advance and compare commands on it.
// ----------------------------------------------------------------------------
// Usage: one command item enters on the req_ channel while req_stall is low,
// and exactly one result item leaves on the rsp_ channel, carrying the held
// date after the command, a status code and the compare flag.
// The block takes one item at a time. After an item is accepted it executes
// a set, compare or unknown command and moves on to the finishing step,
// while an advance stays in the execute step, where the next-day logic
// moves the date on by one day per cycle until the count is used up or the
// date overflows. The finishing step loads the output register, and the
// next item can be accepted in the cycle the result appears.
// The output register lets one result wait while the next item executes. If
// the receiver keeps rsp_stall high, the next result is held back in the
// finishing step and no further item is accepted until the register frees.
// Synchronous reset sets the date to 1 January 1900 and empties the output.
// ----------------------------------------------------------------------------
`default_nettype none

module calendar_date_advance_top #(
   parameter int COUNT_BITS = cda_pkg::COUNT_BITS_DEFAULT
) (
   input  wire              clock,
   input  wire              reset,
   input  wire              req_valid,
   output logic             req_stall,
   input  cda_pkg::req_type req_data,
   output logic             rsp_valid,
   input  wire              rsp_stall,
   output cda_pkg::rsp_type rsp_data
);

   import cda_pkg::*;

   localparam int FIELD_BITS = $bits(req_data.day_count);

   state_type              state_ff, state_in;
   req_type                item_ff, item_in;
   logic [COUNT_BITS-1:0]  cnt_ff, cnt_in;
   logic [4:0]             day_ff, day_in;
   logic [3:0]             month_ff, month_in;
   logic [11:0]            year_ff, year_in;
   logic [6:0]             rem_ff, rem_in;
   logic [5:0]             cent_ff, cent_in;
   logic [2:0]             status_ff, status_in;
   logic                   earlier_ff, earlier_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;

   logic [COUNT_BITS-1:0]  count_w;
   logic                   held_leap_w, set_leap_w;
   logic [3:0]             lim_month_w;
   logic                   lim_leap_w;
   logic [4:0]             lim_days_w;
   logic                   out_free_w;
   logic                   accept_w;

   assign req_stall  = (state_ff != S_IDLE);
   assign accept_w   = req_valid && !req_stall;
   assign out_free_w = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   // Only the low COUNT_BITS bits of the day count are used.
   always_comb begin
      count_w = '0;
      for (int i = 0; i < COUNT_BITS; i++) begin
         if (i < FIELD_BITS) begin
            count_w[i] = req_data.day_count[i];
         end
      end
   end

   // The held year is tracked as century and remainder so the leap rule
   // needs no division.
   assign held_leap_w = (rem_ff == 7'd0) ? (cent_ff[1:0] == 2'b00) : (year_ff[1:0] == 2'b00);
   // Within 1900 to 2100 the only century years that are not leap are the ends.
   assign set_leap_w  = (item_ff.new_year[1:0] == 2'b00) && (item_ff.new_year != YEAR_MIN)
                        && (item_ff.new_year != YEAR_MAX);

   // Shared month length unit: the candidate date on a set, the held one else.
   assign lim_month_w = (item_ff.command == CMD_SET) ? item_ff.new_month : month_ff;
   assign lim_leap_w  = (item_ff.command == CMD_SET) ? set_leap_w : held_leap_w;
   assign lim_days_w  = month_days(lim_month_w, lim_leap_w);

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      cnt_in       = cnt_ff;
      day_in       = day_ff;
      month_in     = month_ff;
      year_in      = year_ff;
      rem_in       = rem_ff;
      cent_in      = cent_ff;
      status_in    = status_ff;
      earlier_in   = earlier_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept_w) begin
               item_in    = req_data;
               cnt_in     = count_w;
               status_in  = ST_OK;
               earlier_in = 1'b0;
               state_in   = S_EXEC;
            end
         end
         S_EXEC: begin
            unique case (item_ff.command)
               CMD_SET: begin
                  state_in = S_FINISH;
                  if ((item_ff.new_month < 4'd1) || (item_ff.new_month > MONTHS_PER_YEAR)) begin
                     status_in = ST_BAD_MONTH;
                  end else if ((item_ff.new_year < YEAR_MIN) || (item_ff.new_year > YEAR_MAX)) begin
                     status_in = ST_BAD_YEAR;
                  end else if ((item_ff.new_day < 5'd1) || (item_ff.new_day > lim_days_w)) begin
                     status_in = ST_BAD_DAY;
                  end else begin
                     day_in   = item_ff.new_day;
                     month_in = item_ff.new_month;
                     year_in  = item_ff.new_year;
                     if (item_ff.new_year >= YEAR_MAX) begin
                        rem_in  = 7'(item_ff.new_year - YEAR_MAX);
                        cent_in = CENT_MAX;
                     end else if (item_ff.new_year >= YEAR_MID) begin
                        rem_in  = 7'(item_ff.new_year - YEAR_MID);
                        cent_in = CENT_MID;
                     end else begin
                        rem_in  = 7'(item_ff.new_year - YEAR_MIN);
                        cent_in = CENT_MIN;
                     end
                  end
               end
               CMD_ADVANCE: begin
                  if (cnt_ff == '0) begin
                     state_in = S_FINISH;
                  end else if (day_ff < lim_days_w) begin
                     day_in = day_ff + 5'd1;
                     cnt_in = cnt_ff - 1'b1;
                  end else if (month_ff < MONTHS_PER_YEAR) begin
                     month_in = month_ff + 4'd1;
                     day_in   = 5'd1;
                     cnt_in   = cnt_ff - 1'b1;
                  end else if (year_ff >= TOP_YEAR) begin
                     // Last date that can be held: days are still owed.
                     status_in = ST_OVERFLOW;
                     state_in  = S_FINISH;
                  end else begin
                     year_in  = year_ff + 12'd1;
                     month_in = 4'd1;
                     day_in   = 5'd1;
                     cnt_in   = cnt_ff - 1'b1;
                     if (rem_ff == LAST_REM) begin
                        rem_in  = 7'd0;
                        cent_in = cent_ff + 6'd1;
                     end else begin
                        rem_in = rem_ff + 7'd1;
                     end
                  end
               end
               CMD_COMPARE: begin
                  state_in = S_FINISH;
                  if (year_ff < item_ff.new_year) begin
                     earlier_in = 1'b1;
                  end else if ((year_ff == item_ff.new_year) && (month_ff < item_ff.new_month)) begin
                     earlier_in = 1'b1;
                  end else if ((year_ff == item_ff.new_year) && (month_ff == item_ff.new_month)
                               && (day_ff < item_ff.new_day)) begin
                     earlier_in = 1'b1;
                  end
               end
               default: begin
                  state_in = S_FINISH;
               end
            endcase
         end
         S_FINISH: begin
            if (out_free_w) begin
               rsp_in.cur_day    = day_ff;
               rsp_in.cur_month  = month_ff;
               rsp_in.cur_year   = year_ff;
               rsp_in.status     = status_ff;
               rsp_in.is_earlier = earlier_ff;
               rsp_valid_in      = 1'b1;
               state_in          = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         day_ff       <= 5'd1;
         month_ff     <= 4'd1;
         year_ff      <= YEAR_MIN;
         rem_ff       <= 7'd0;
         cent_ff      <= CENT_MIN;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         day_ff       <= day_in;
         month_ff     <= month_in;
         year_ff      <= year_in;
         rem_ff       <= rem_in;
         cent_ff      <= cent_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff    <= item_in;
      cnt_ff     <= cnt_in;
      status_ff  <= status_in;
      earlier_ff <= earlier_in;
      rsp_ff     <= rsp_in;
   end

endmodule

`default_nettype wire

// ===== rtl/cda_checker.sv =====
// ----------------------------------------------------------------------------
// cda_props
// Port-level checks on the calendar date block, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cda_props (
   input wire              clock,
   input wire              reset,
   input wire              req_valid,
   input wire              req_stall,
   input wire              rsp_valid,
   input wire              rsp_stall,
   input cda_pkg::rsp_type rsp_data
);

   import cda_pkg::*;

   // A waiting result stays put until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed or vanished");

   // An accepted item keeps the block busy in the following cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("block accepted two items in consecutive cycles");

   // Overflow only ever leaves the date on the last day it can hold.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == ST_OVERFLOW) |->
         (rsp_data.cur_day == 5'd31) && (rsp_data.cur_month == MONTHS_PER_YEAR)
         && (rsp_data.cur_year == TOP_YEAR))
      else $error("overflow reported away from the last date");

   // The compare flag comes only with a clean status and a proper month.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_data.is_earlier || (rsp_data.status == ST_OK))
         && (rsp_data.cur_month >= 4'd1) && (rsp_data.cur_month <= MONTHS_PER_YEAR))
      else $error("inconsistent result item");

   // Reset empties the output.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind calendar_date_advance_top cda_props u_cda_props (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire
